@@ hdl/status_response_deframer_macros.svh @@
// Assertion helpers for the status response deframer checker.
`ifndef STATUS_RESPONSE_DEFRAMER_MACROS_SVH
`define STATUS_RESPONSE_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/srd_pkg.sv @@
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and character codes for the status response deframer.
// ----------------------------------------------------------------------------
package srd_pkg;

    // Control characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_FS  = 8'h1C;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_DC2 = 8'h12;
    localparam logic [7:0] CH_DC4 = 8'h14;

    // Result kinds
    localparam logic [2:0] K_ARG     = 3'd0;
    localparam logic [2:0] K_DONE    = 3'd1;
    localparam logic [2:0] K_NAK     = 3'd2;
    localparam logic [2:0] K_TIMEOUT = 3'd3;
    localparam logic [2:0] K_BUSY    = 3'd4;
    localparam logic [2:0] K_PAPER   = 3'd5;

    // Input word function codes
    localparam logic F_BYTE    = 1'b0;
    localparam logic F_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic        is_separator;
        logic [7:0]  frame_sequence;
        logic [15:0] printer_status;
        logic [15:0] fiscal_status;
        logic [15:0] error_code;
        logic [15:0] argument_count;
    } t_result;

endpackage

@@ hdl/srd_in_reg.sv @@
// ----------------------------------------------------------------------------
// srd_in_reg
// Input holding register; stalls the sender only while a held word cannot move.
// ----------------------------------------------------------------------------
module srd_in_reg
    import srd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hdl/srd_parser.sv @@
// ----------------------------------------------------------------------------
// srd_parser
// Frame parser state and single-pass next-state / result logic.
// ----------------------------------------------------------------------------
module srd_parser
    import srd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_item      i_item,
    input  logic [3:0] i_paper_period,
    output logic       o_has_result,
    output t_result    o_result
);

    typedef enum logic [4:0] {
        ST_SEQ    = 5'd0,
        ST_PS_HI  = 5'd1,
        ST_PS_LO  = 5'd2,
        ST_SEP_A  = 5'd3,
        ST_FS_HI  = 5'd4,
        ST_FS_LO  = 5'd5,
        ST_SEP_B  = 5'd6,
        ST_SEP_C  = 5'd7,
        ST_ERR_HI = 5'd8,
        ST_ERR_LO = 5'd9,
        ST_SEP_D  = 5'd10,
        ST_ARG    = 5'd11,
        ST_ESC    = 5'd12,
        ST_CK0    = 5'd13,
        ST_CK1    = 5'd14,
        ST_CK2    = 5'd15,
        ST_CK3    = 5'd16
    } t_stage;

    logic        r_hunting, n_hunting;
    t_stage      r_stage, n_stage;
    logic [7:0]  r_seq, n_seq;
    logic [15:0] r_printer, n_printer;
    logic [15:0] r_fiscal, n_fiscal;
    logic [15:0] r_error, n_error;
    logic [15:0] r_count, n_count;
    logic [3:0]  r_paper, n_paper;
    logic        has;
    t_result     res;
    logic [7:0]  b;

    assign b = i_item.rx_byte;

    always_comb begin
        n_hunting = r_hunting;
        n_stage   = r_stage;
        n_seq     = r_seq;
        n_printer = r_printer;
        n_fiscal  = r_fiscal;
        n_error   = r_error;
        n_count   = r_count;
        n_paper   = r_paper;
        has       = 1'b0;
        res       = '0;

        if (i_item.func == F_TIMEOUT) begin
            // abort any frame in flight
            n_hunting = 1'b1;
            n_stage   = ST_SEQ;
            has       = 1'b1;
            res.kind  = K_TIMEOUT;
        end else if (r_hunting) begin
            priority if (b == CH_NAK) begin
                has      = 1'b1;
                res.kind = K_NAK;
            end else if (b == CH_DC4) begin
                has      = 1'b1;
                res.kind = K_BUSY;
            end else if (b == CH_DC2) begin
                if (r_paper > 4'd1) begin
                    n_paper = r_paper - 4'd1;
                end else begin
                    n_paper  = i_paper_period;
                    has      = 1'b1;
                    res.kind = K_PAPER;
                end
            end else if (b == CH_STX) begin
                n_hunting = 1'b0;
                n_stage   = ST_SEQ;
                n_count   = '0;
            end else begin
                n_hunting = r_hunting;
            end
        end else begin
            unique case (r_stage)
                ST_SEQ: begin
                    n_seq   = b;
                    n_stage = ST_PS_HI;
                end
                ST_PS_HI: begin
                    n_printer = {b, 8'h00};
                    n_stage   = ST_PS_LO;
                end
                ST_PS_LO: begin
                    n_printer = {r_printer[15:8], b};
                    n_stage   = ST_SEP_A;
                end
                ST_SEP_A: if (b == CH_FS) n_stage = ST_FS_HI;
                ST_FS_HI: begin
                    n_fiscal = {b, 8'h00};
                    n_stage  = ST_FS_LO;
                end
                ST_FS_LO: begin
                    n_fiscal = {r_fiscal[15:8], b};
                    n_stage  = ST_SEP_B;
                end
                ST_SEP_B: if (b == CH_FS) n_stage = ST_SEP_C;
                // reserved field skipped up to its separator
                ST_SEP_C: if (b == CH_FS) n_stage = ST_ERR_HI;
                ST_ERR_HI: begin
                    n_error = {b, 8'h00};
                    n_stage = ST_ERR_LO;
                end
                ST_ERR_LO: begin
                    n_error = {r_error[15:8], b};
                    n_stage = ST_SEP_D;
                end
                ST_SEP_D: if (b == CH_FS) n_stage = ST_ARG;
                ST_ARG: begin
                    priority if (b == CH_ETX) begin
                        n_stage = ST_CK0;
                    end else if (b == CH_ESC) begin
                        n_stage = ST_ESC;
                    end else begin
                        has              = 1'b1;
                        res.kind         = K_ARG;
                        res.data_byte    = b;
                        res.is_separator = (b == CH_FS);
                        if (r_count != 16'hFFFF) n_count = r_count + 16'd1;
                    end
                end
                ST_ESC: begin
                    // literal byte, then back to argument bytes
                    n_stage       = ST_ARG;
                    has           = 1'b1;
                    res.kind      = K_ARG;
                    res.data_byte = b;
                    if (r_count != 16'hFFFF) n_count = r_count + 16'd1;
                end
                ST_CK0: n_stage = ST_CK1;
                ST_CK1: n_stage = ST_CK2;
                ST_CK2: n_stage = ST_CK3;
                ST_CK3: begin
                    n_hunting          = 1'b1;
                    n_stage            = ST_SEQ;
                    has                = 1'b1;
                    res.kind           = K_DONE;
                    res.frame_sequence = r_seq;
                    res.printer_status = r_printer;
                    res.fiscal_status  = r_fiscal;
                    res.error_code     = r_error;
                    res.argument_count = r_count;
                end
                default: begin
                    n_hunting = 1'b1;
                    n_stage   = ST_SEQ;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting <= 1'b1;
            r_stage   <= ST_SEQ;
            r_seq     <= '0;
            r_printer <= '0;
            r_fiscal  <= '0;
            r_error   <= '0;
            r_count   <= '0;
            r_paper   <= '0;
        end else if (i_advance) begin
            r_hunting <= n_hunting;
            r_stage   <= n_stage;
            r_seq     <= n_seq;
            r_printer <= n_printer;
            r_fiscal  <= n_fiscal;
            r_error   <= n_error;
            r_count   <= n_count;
            r_paper   <= n_paper;
        end
    end

    assign o_has_result = has;
    assign o_result     = res;

endmodule

@@ hdl/srd_out_reg.sv @@
// ----------------------------------------------------------------------------
// srd_out_reg
// Result register; holds a word until the receiver takes it.
// ----------------------------------------------------------------------------
module srd_out_reg
    import srd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid && i_stall;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hdl/status_response_deframer.sv @@
// ----------------------------------------------------------------------------
// status_response_deframer
// Receive-side deframer for STX/ETX status responses with ESC byte stuffing.
//
// Takes one word per clock when not stalled: a received byte or a
// receive timeout. Each word sits in an input register, is parsed in a
// single pass of logic and, if it produces a result, lands in the result
// register, so the block sustains one word per cycle unless stalled.
// The sender is stalled only when a result already waits in the
// output register and the receiver is stalling it. While
// hunting for STX, NAK, DC4 and DC2 report nak, busy and paper-out (DC2
// paced by paper_notice_period). Inside a frame, argument bytes come out
// one per result with FS flagged; a done result after the fourth checksum
// character carries the header words and the saturating argument count.
// Checksum characters are not verified. A timeout always reports and drops
// any partial frame. The single configuration register is written through
// a valid/ready port that is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module status_response_deframer
    import srd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_paper_notice_period,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_is_separator,
    output logic [7:0]  o_frame_sequence,
    output logic [15:0] o_printer_status,
    output logic [15:0] o_fiscal_status,
    output logic [15:0] o_error_code,
    output logic [15:0] o_argument_count
);

    logic [3:0] r_paper_period;
    t_item      in_item;
    t_item      held_item;
    logic       held_valid;
    logic       out_free;
    logic       advance;
    logic       has_result;
    t_result    next_result;
    t_result    out_result;

    // config register, reset value 4
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paper_period <= 4'd4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_paper_period <= i_cfg_paper_notice_period;
        end
    end

    assign in_item.func    = i_func;
    assign in_item.rx_byte = i_rx_byte;

    // a held word moves on whenever the result register can take a word
    assign advance = held_valid && out_free;

    srd_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    srd_parser u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_item         (held_item),
        .i_paper_period (r_paper_period),
        .o_has_result   (has_result),
        .o_result       (next_result)
    );

    srd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (next_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_kind           = out_result.kind;
    assign o_data_byte      = out_result.data_byte;
    assign o_is_separator   = out_result.is_separator;
    assign o_frame_sequence = out_result.frame_sequence;
    assign o_printer_status = out_result.printer_status;
    assign o_fiscal_status  = out_result.fiscal_status;
    assign o_error_code     = out_result.error_code;
    assign o_argument_count = out_result.argument_count;

endmodule

@@ hdl/srd_checker.sv @@
// ----------------------------------------------------------------------------
// srd_checker
// Port-level checks on the status response deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "status_response_deframer_macros.svh"

module srd_checker
    import srd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_data_byte,
    input logic        o_is_separator,
    input logic [7:0]  o_frame_sequence,
    input logic [15:0] o_printer_status,
    input logic [15:0] o_fiscal_status,
    input logic [15:0] o_error_code,
    input logic [15:0] o_argument_count
);

    // stalled result word holds
    `SRD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_data_byte) && $stable(o_argument_count), "stalled result changed")

    // the sender is only held back by a stalled receiver
    `SRD_ASSERT_NOW(a_no_spurious_stall, !i_out_stall, !o_in_stall, "input stalled with output free")

    // non-argument results carry no byte
    `SRD_ASSERT_NOW(a_arg_fields, o_out_valid && o_kind != K_ARG, o_data_byte == 8'd0 && !o_is_separator, "byte field set on non-argument result")

    // header fields only on a done result
    `SRD_ASSERT_NOW(a_done_fields, o_out_valid && o_kind != K_DONE, o_frame_sequence == 8'd0 && o_printer_status == 16'd0 && o_fiscal_status == 16'd0 && o_error_code == 16'd0 && o_argument_count == 16'd0, "header field set on non-done result")

endmodule

bind status_response_deframer srd_checker u_srd_checker (.*);

@@ dv/tb_status_response_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_response_deframer
// Self-checking bench for the status response deframer. A short table of
// hand-picked words (hunt-mode notices, header extremes, escaping, checksum
// skip, timeout) runs first. Random phases follow: well-formed frames with
// random content, truncated frames, and hunt-mode noise, one phase per
// notice-period setting. Each result is checked against a hand-pinned or
// bench-modelled expectation, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_status_response_deframer;
    import srd_pkg::*;

    localparam int IDLE_LIMIT     = 2000;   // cycles without any handshake
    localparam int SETTLE_CYCLES  = 4;      // margin for words still in the input and result registers
    localparam int PHASE_WORDS    = 390;    // words per random phase; five phases
    localparam int REPORT_MAX     = 10;

    // Parse steps with a name of their own; the header steps are numbered.
    localparam logic [4:0] STEP_ARGS    = 5'd11;
    localparam logic [4:0] STEP_ESCAPED = 5'd12;
    localparam logic [4:0] STEP_CKSUM   = 5'd13;
    localparam logic [4:0] STEP_DONE    = 5'd16;

    // One directed word: either the expectation is pinned by hand, or the
    // bench model works it out.
    typedef struct packed {
        logic    typed;
        logic    yields;
        t_item   w;
        t_result res;
    } t_row;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_paper_notice_period = 4'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = F_BYTE;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic        o_is_separator;
    logic [7:0]  o_frame_sequence;
    logic [15:0] o_printer_status;
    logic [15:0] o_fiscal_status;
    logic [15:0] o_error_code;
    logic [15:0] o_argument_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    status_response_deframer u_dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg_valid               (i_cfg_valid),
        .o_cfg_ready               (o_cfg_ready),
        .i_cfg_paper_notice_period (i_cfg_paper_notice_period),
        .i_in_valid                (i_in_valid),
        .o_in_stall                (o_in_stall),
        .i_func                    (i_func),
        .i_rx_byte                 (i_rx_byte),
        .o_out_valid               (o_out_valid),
        .i_out_stall               (i_out_stall),
        .o_kind                    (o_kind),
        .o_data_byte               (o_data_byte),
        .o_is_separator            (o_is_separator),
        .o_frame_sequence          (o_frame_sequence),
        .o_printer_status          (o_printer_status),
        .o_fiscal_status           (o_fiscal_status),
        .o_error_code              (o_error_code),
        .o_argument_count          (o_argument_count)
    );

    // ------------------------------------------------------------------
    // Bench-side deframer state, starting at its reset values
    // ------------------------------------------------------------------
    logic        hunt_mode     = 1'b1;
    logic [4:0]  parse_step    = 5'd0;
    logic [7:0]  seq_byte      = 8'h00;
    logic [15:0] printer_word  = 16'h0000;
    logic [15:0] fiscal_word   = 16'h0000;
    logic [15:0] error_word    = 16'h0000;
    logic [15:0] arg_total     = 16'h0000;
    logic [3:0]  dc2_left      = 4'd0;
    logic [3:0]  notice_period = 4'd4;

    t_result     due_results[$];     // expectations, oldest first
    logic [7:0]  frame_bytes[$];     // frame being built for sending

    // Hand-pinned expectation travels with the word, registered like payload
    logic        pin_on = 1'b0;
    logic        pin_yield = 1'b0;
    t_result     pin_res = '0;

    int          send_quiet = 0;
    int          recv_quiet = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          n_words = 0;
    int          n_results = 0;
    int          n_frames = 0;
    int          n_errors = 0;
    int          n_settings = 0;
    int          max_args = 0;

    // ------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------
    function automatic t_result arg_result(logic [7:0] b, logic sep);
        t_result r;
        r = '0;
        r.kind = K_ARG;
        r.data_byte = b;
        r.is_separator = sep;
        if (arg_total != 16'hFFFF)
            arg_total++;
        return r;
    endfunction

    // One word through the deframer; at most one result comes of it.
    function automatic void deframe_step(input t_item w, output bit yields,
                                         output t_result r);
        logic [7:0] b;
        b = w.rx_byte;
        r = '0;
        yields = 1'b0;

        // A timeout drops whatever was in flight, from any step
        if (w.func == F_TIMEOUT) begin
            hunt_mode = 1'b1;
            parse_step = 5'd0;
            r.kind = K_TIMEOUT;
            yields = 1'b1;
            return;
        end

        if (hunt_mode) begin
            case (b)
                CH_NAK: begin
                    r.kind = K_NAK;
                    yields = 1'b1;
                end
                CH_DC4: begin
                    r.kind = K_BUSY;
                    yields = 1'b1;
                end
                CH_DC2: begin
                    // paced: only every notice_period-th DC2 is reported
                    if (dc2_left > 4'd1) begin
                        dc2_left--;
                    end else begin
                        dc2_left = notice_period;
                        r.kind = K_PAPER;
                        yields = 1'b1;
                    end
                end
                CH_STX: begin
                    hunt_mode = 1'b0;
                    parse_step = 5'd0;
                    arg_total = 16'h0000;
                end
                default: ;
            endcase
            return;
        end

        case (parse_step)
            5'd0: begin
                seq_byte = b;
                parse_step = 5'd1;
            end
            5'd1: begin
                printer_word = {b, 8'h00};
                parse_step = 5'd2;
            end
            5'd2: begin
                printer_word = printer_word | {8'h00, b};
                parse_step = 5'd3;
            end
            // separator waits; step 7 also skips the reserved field
            5'd3, 5'd6, 5'd7, 5'd10: begin
                if (b == CH_FS)
                    parse_step++;
            end
            5'd4: begin
                fiscal_word = {b, 8'h00};
                parse_step = 5'd5;
            end
            5'd5: begin
                fiscal_word = fiscal_word | {8'h00, b};
                parse_step = 5'd6;
            end
            5'd8: begin
                error_word = {b, 8'h00};
                parse_step = 5'd9;
            end
            5'd9: begin
                error_word = error_word | {8'h00, b};
                parse_step = 5'd10;
            end
            STEP_ARGS: begin
                if (b == CH_ETX) begin
                    parse_step = STEP_CKSUM;
                end else if (b == CH_ESC) begin
                    parse_step = STEP_ESCAPED;
                end else begin
                    r = arg_result(b, b == CH_FS);
                    yields = 1'b1;
                end
            end
            STEP_ESCAPED: begin
                // literal byte, then straight back to arguments
                parse_step = STEP_ARGS;
                r = arg_result(b, 1'b0);
                yields = 1'b1;
            end
            STEP_CKSUM, 5'd14, 5'd15: begin
                parse_step++;
            end
            STEP_DONE: begin
                hunt_mode = 1'b1;
                parse_step = 5'd0;
                r.kind = K_DONE;
                r.frame_sequence = seq_byte;
                r.printer_status = printer_word;
                r.fiscal_status = fiscal_word;
                r.error_code = error_word;
                r.argument_count = arg_total;
                yields = 1'b1;
            end
            default: begin
                hunt_mode = 1'b1;
                parse_step = 5'd0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic string show(t_result r);
        return $sformatf("kind %0d data %02h sep %0d seq %02h prn %04h fis %04h err %04h cnt %0d",
                         r.kind, r.data_byte, r.is_separator, r.frame_sequence,
                         r.printer_status, r.fiscal_status, r.error_code, r.argument_count);
    endfunction

    task automatic report(input string what, input bit has_exp, input t_result e,
                          input t_result a);
        n_errors++;
        if (n_errors <= REPORT_MAX) begin
            $display("ERROR %s at %0t", what, $realtime);
            if (has_exp)
                $display("  exp %s", show(e));
            $display("  got %s", show(a));
        end
    endtask

    // All three channels sampled on pre-edge values. Results are checked
    // before the accepted word is modelled, so the store stays in order.
    always @(posedge i_clk) begin : watch
        t_result seen;
        t_result want;
        bit      yields;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                n_results++;
                seen = {o_kind, o_data_byte, o_is_separator, o_frame_sequence,
                        o_printer_status, o_fiscal_status, o_error_code,
                        o_argument_count};
                if (due_results.size() == 0) begin
                    report("result with nothing expected", 1'b0, '0, seen);
                end else begin
                    want = due_results.pop_front();
                    if (seen !== want)
                        report("result mismatch", 1'b1, want, seen);
                    if (want.kind == K_DONE) begin
                        n_frames++;
                        if (int'(want.argument_count) > max_args)
                            max_args = int'(want.argument_count);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                deframe_step({i_func, i_rx_byte}, yields, want);
                if (pin_on) begin
                    yields = pin_yield;
                    want = pin_res;
                end
                if (yields)
                    due_results.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                notice_period = i_cfg_paper_notice_period;
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, due_results.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Gaps and stalls
    // ------------------------------------------------------------------
    // Random idle gap before each word, with occasional runs of back-to-back words
    function automatic int pick_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Receiver: after each result taken, hold off the next one for a
    // freshly drawn number of valid cycles.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            stall_left = pick_wait(recv_quiet);
        else if (o_out_valid && stall_left > 0)
            stall_left--;
        i_out_stall <= (stall_left > 0);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic t_row predicted_row(logic f, logic [7:0] b);
        t_row r;
        r = '0;
        r.w.func = f;
        r.w.rx_byte = b;
        return r;
    endfunction

    function automatic t_row known_row(logic f, logic [7:0] b, logic y,
                                       logic [2:0] k);
        t_row r;
        r = predicted_row(f, b);
        r.typed = 1'b1;
        r.yields = y;
        r.res.kind = k;
        return r;
    endfunction

    // Valid is only lowered when a gap is drawn, so a word that follows
    // straight on keeps valid high with a single update per edge.
    task automatic send_row(input t_row r);
        int gap;
        gap = pick_wait(send_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= r.w.func;
        i_rx_byte  <= r.w.rx_byte;
        pin_on     <= r.typed;
        pin_yield  <= r.yields;
        pin_res    <= r.res;
        do @(posedge i_clk); while (o_in_stall);
        n_words++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_row(predicted_row(F_BYTE, b));
    endtask

    task automatic send_timeout();
        send_row(predicted_row(F_TIMEOUT, 8'($urandom_range(0, 255))));
    endtask

    function automatic logic [7:0] header_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // FS, optionally preceded by junk that the separator wait must skip
    function automatic void push_separator(int junk_max);
        logic [7:0] b;
        repeat ($urandom_range(0, junk_max)) begin
            b = 8'($urandom_range(0, 255));
            frame_bytes.push_back((b == CH_FS) ? 8'h00 : b);
        end
        frame_bytes.push_back(CH_FS);
    endfunction

    // Well-formed frame with n_args argument bytes and random content
    function automatic void build_frame(int n_args);
        logic [7:0] b;
        int         junk;
        frame_bytes.delete();
        junk = ($urandom_range(0, 3) == 0) ? 2 : 0;
        frame_bytes.push_back(CH_STX);
        repeat (3) frame_bytes.push_back(header_byte());   // sequence, printer
        push_separator(junk);
        repeat (2) frame_bytes.push_back(header_byte());   // fiscal
        push_separator(junk);
        push_separator(3);                                  // reserved field
        repeat (2) frame_bytes.push_back(header_byte());   // error code
        push_separator(junk);
        repeat (n_args) begin
            b = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0: begin
                    frame_bytes.push_back(CH_ESC);
                    frame_bytes.push_back(b);
                end
                1: frame_bytes.push_back(CH_FS);
                default: begin
                    if (b == CH_ETX || b == CH_ESC)
                        frame_bytes.push_back(CH_ESC);
                    frame_bytes.push_back(b);
                end
            endcase
        end
        frame_bytes.push_back(CH_ETX);
        repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // A cut frame stops at a random word and is dropped by a timeout
    task automatic send_frame(input int n_args, input bit cut);
        int stop;
        build_frame(n_args);
        stop = cut ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
        for (int k = 0; k < stop; k++)
            send_byte(frame_bytes[k]);
        if (cut)
            send_timeout();
    endtask

    // Hunt-mode traffic; STX is kept out so the next frame starts clean
    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0:       send_byte(CH_NAK);
                1:       send_byte(CH_DC4);
                2, 3:    send_byte(CH_DC2);
                4:       send_timeout();
                default: send_byte((b == CH_STX) ? 8'h00 : b);
            endcase
        end
    endtask

    // Idle: every expectation met, then room for words still in the pipe
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [3:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_paper_notice_period <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin : stimulus
        t_row       plan[$];
        logic [3:0] period_plan[5];
        int         phase_end;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset period of four
        plan = '{
            known_row(F_BYTE, CH_NAK, 1'b1, K_NAK),
            known_row(F_BYTE, CH_DC4, 1'b1, K_BUSY),
            known_row(F_BYTE, CH_DC2, 1'b1, K_PAPER),     // countdown reloads
            known_row(F_BYTE, CH_DC2, 1'b0, K_ARG),       // paced away
            known_row(F_BYTE, 8'hFF, 1'b0, K_ARG),        // ignored in hunt
            known_row(F_TIMEOUT, 8'h00, 1'b1, K_TIMEOUT),
            predicted_row(F_BYTE, CH_STX),
            predicted_row(F_BYTE, CH_STX),                // STX as sequence
            predicted_row(F_BYTE, 8'hFF),                 // printer FFFF
            predicted_row(F_BYTE, 8'hFF),
            predicted_row(F_BYTE, CH_FS),
            predicted_row(F_BYTE, 8'h00),                 // fiscal 0000
            predicted_row(F_BYTE, 8'h00),
            predicted_row(F_BYTE, CH_FS),
            predicted_row(F_BYTE, CH_FS),                 // empty reserved
            predicted_row(F_BYTE, 8'hA5),                 // error A55A
            predicted_row(F_BYTE, 8'h5A),
            predicted_row(F_BYTE, CH_FS),
            predicted_row(F_BYTE, CH_FS),                 // flagged separator
            predicted_row(F_BYTE, CH_ESC),
            predicted_row(F_BYTE, CH_ETX),                // literal ETX
            predicted_row(F_BYTE, CH_ETX),                // must still end it
            predicted_row(F_BYTE, 8'hFF),                 // checksum skipped
            predicted_row(F_BYTE, 8'h00),
            predicted_row(F_BYTE, CH_ESC),
            predicted_row(F_BYTE, CH_FS),                 // done here
            predicted_row(F_BYTE, CH_STX),
            known_row(F_TIMEOUT, 8'hFF, 1'b1, K_TIMEOUT)  // mid-frame drop
        };
        foreach (plan[k])
            send_row(plan[k]);

        // Random phases, one notice period each; zero reports every DC2
        period_plan = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 14)), 4'd7};
        for (int ph = 0; ph < 5; ph++) begin
            write_period(period_plan[ph]);
            phase_end = n_words + PHASE_WORDS;
            while (n_words < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                               : $urandom_range(0, 12),
                                   1'b0);
                    6:       send_frame($urandom_range(0, 12), 1'b1);
                    default: send_noise();
                endcase
            end
        end

        settle();

        if (due_results.size() != 0) begin
            $display("ERROR %0d expected results never arrived", due_results.size());
            n_errors += due_results.size();
        end

        $display("summary: %0d words in, %0d results checked, %0d frames closed, longest %0d args",
                 n_words, n_results, n_frames, max_args);
        $display("summary: %0d notice periods written (0, 1 and 15 among them), %0d errors",
                 n_settings, n_errors);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/srd_pkg.sv
hdl/srd_in_reg.sv
hdl/srd_parser.sv
hdl/srd_out_reg.sv
hdl/status_response_deframer.sv
hdl/srd_checker.sv
dv/tb_status_response_deframer.sv
